>>> rtl/core/fla_pkg.sv
// Shared types and constants of the free list allocator.
package fla_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] PAGE_MASK_LOW  = 32'h0000_0fff;
    localparam logic [DATA_W-1:0] PAGE_MASK_HIGH = 32'hffff_f000;
    localparam logic [DATA_W-1:0] ALL_ONES       = 32'hffff_ffff;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_LOST  = 2'd2
    } fla_status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } fla_alu_op_t;

    typedef struct packed {
        fla_alu_op_t       op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } fla_alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              carry;
    } fla_alu_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_A_RD,
        ST_A_CHK,
        ST_A_UPD,
        ST_RM_RD,
        ST_RM_WR,
        ST_F_RD,
        ST_F_CHK,
        ST_F_PREV,
        ST_F_MRG,
        ST_F_MRG_CHK,
        ST_F_MRG2,
        ST_F_NEXT,
        ST_F_NXT_MRG,
        ST_IN_RD,
        ST_IN_WR,
        ST_IN_PUT,
        ST_LOST1,
        ST_LOST2,
        ST_S_INIT,
        ST_S_RD,
        ST_S_ADD,
        ST_FINISH
    } fla_state_t;

endpackage

>>> rtl/core/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/fla_alu.sv
// Shared 32-bit add/subtract unit with carry out.
module fla_alu (
    input  fla_pkg::fla_alu_req_t req,
    output fla_pkg::fla_alu_rsp_t rsp
);

    logic [fla_pkg::DATA_W:0]   sum;
    logic [fla_pkg::DATA_W-1:0] b_op;

    always_comb
    begin
        b_op = (req.op == fla_pkg::ALU_SUB) ? ~req.b : req.b;
        sum  = {1'b0, req.a} + {1'b0, b_op}
             + (fla_pkg::DATA_W+1)'(req.op == fla_pkg::ALU_SUB);
        rsp.res   = sum[fla_pkg::DATA_W-1:0];
        rsp.carry = sum[fla_pkg::DATA_W];
    end

endmodule

>>> rtl/core/free_list_allocator.sv
// Top level: first-fit free list allocator with coalescing, sequencer and datapath.
// One transaction at a time: a request scans the table, may shift entries up or down,
// then sums all held lengths. Scan and shift together never cover more than the held
// entries. Every table access goes through the single table port and every sum through
// the one shared 32-bit adder. A finished result waits in an output register; the next
// request is taken while it waits. The table RAM needs no clearing after reset.
module free_list_allocator #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] addr,
    input  logic [31:0] size,
    input  logic        page_round,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] alloc_addr,
    output logic [31:0] free_total,
    output logic [8:0]  entry_count,
    output logic [8:0]  peak_entries,
    output logic [31:0] lost_count,
    output logic [31:0] lost_bytes
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int DW    = fla_pkg::DATA_W;

    fla_pkg::fla_state_t   state_reg, state_next;
    fla_pkg::fla_alu_req_t alu_req;
    fla_pkg::fla_alu_rsp_t alu_rsp;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [DW-1:0]    lost_cnt_reg, lost_cnt_next;
    logic [DW-1:0]    lost_bytes_reg, lost_bytes_next;
    logic             out_valid_reg, out_valid_next;

    logic             func_reg, func_next;
    logic             round_reg, round_next;
    logic [DW-1:0]    addr_reg, addr_next;
    logic [DW-1:0]    size_reg, size_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [DW-1:0]    cur_start_reg, cur_start_next;
    logic [DW-1:0]    prev_start_reg, prev_start_next;
    logic [DW-1:0]    prev_len_reg, prev_len_next;
    logic [DW-1:0]    next_start_reg, next_start_next;
    logic [DW-1:0]    next_len_reg, next_len_next;
    logic             next_ok_reg, next_ok_next;
    logic [DW-1:0]    tmp_reg, tmp_next;
    logic [DW-1:0]    sum_reg, sum_next;
    logic [DW-1:0]    got_reg, got_next;
    logic [1:0]       stat_reg, stat_next;

    logic [1:0]       o_status_reg, o_status_next;
    logic [DW-1:0]    o_addr_reg, o_addr_next;
    logic [DW-1:0]    o_total_reg, o_total_next;
    logic [8:0]       o_count_reg, o_count_next;
    logic [8:0]       o_peak_reg, o_peak_next;
    logic [DW-1:0]    o_lcnt_reg, o_lcnt_next;
    logic [DW-1:0]    o_lbytes_reg, o_lbytes_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [2*DW-1:0]  ram_wdata, ram_rdata;
    logic [DW-1:0]    rd_start, rd_len;

    logic [CNT_W-1:0] k_inc, k_dec, i_dec, count_inc;
    logic             at_end, sum_eq_addr, sum_eq_next, has_room, can_load;
    logic [DW-1:0]    sat_res;

    fla_ram #(
        .WIDTH (2 * DW),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fla_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rd_start    = ram_rdata[2*DW-1:DW];
    assign rd_len      = ram_rdata[DW-1:0];
    assign k_inc       = k_reg + CNT_W'(1);
    assign k_dec       = k_reg - CNT_W'(1);
    assign i_dec       = i_reg - CNT_W'(1);
    assign count_inc   = count_reg + CNT_W'(1);
    assign at_end      = (i_reg == count_reg);
    assign sum_eq_addr = (alu_rsp.res == addr_reg);
    assign sum_eq_next = next_ok_reg && (alu_rsp.res == next_start_reg);
    assign has_room    = (count_reg < CNT_W'(ENTRIES));
    assign can_load    = !out_valid_reg || !out_stall;
    assign sat_res     = alu_rsp.carry ? fla_pkg::ALL_ONES : alu_rsp.res;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fla_pkg::ST_IDLE:      if (in_valid) state_next = fla_pkg::ST_PREP;
            fla_pkg::ST_PREP:      state_next = func_reg ? fla_pkg::ST_F_RD : fla_pkg::ST_A_RD;
            fla_pkg::ST_A_RD:      state_next = at_end ? fla_pkg::ST_S_INIT : fla_pkg::ST_A_CHK;
            fla_pkg::ST_A_CHK:     state_next = alu_rsp.carry ? fla_pkg::ST_A_UPD
                                                              : fla_pkg::ST_A_RD;
            fla_pkg::ST_A_UPD:     state_next = (tmp_reg == '0) ? fla_pkg::ST_RM_RD
                                                                : fla_pkg::ST_S_INIT;
            fla_pkg::ST_RM_RD:     state_next = (k_reg < count_reg) ? fla_pkg::ST_RM_WR
                                                                    : fla_pkg::ST_S_INIT;
            fla_pkg::ST_RM_WR:     state_next = fla_pkg::ST_RM_RD;
            fla_pkg::ST_F_RD:      state_next = at_end ? fla_pkg::ST_F_PREV : fla_pkg::ST_F_CHK;
            fla_pkg::ST_F_CHK:     state_next = alu_rsp.carry ? fla_pkg::ST_F_RD
                                                              : fla_pkg::ST_F_PREV;
            fla_pkg::ST_F_PREV:
            begin
                if (i_reg != '0 && sum_eq_addr)
                    state_next = fla_pkg::ST_F_MRG;
                else
                    state_next = fla_pkg::ST_F_NEXT;
            end
            fla_pkg::ST_F_MRG:     state_next = fla_pkg::ST_F_MRG_CHK;
            fla_pkg::ST_F_MRG_CHK: state_next = sum_eq_next ? fla_pkg::ST_F_MRG2
                                                            : fla_pkg::ST_S_INIT;
            fla_pkg::ST_F_MRG2:    state_next = fla_pkg::ST_RM_RD;
            fla_pkg::ST_F_NEXT:
            begin
                if (sum_eq_next)
                    state_next = fla_pkg::ST_F_NXT_MRG;
                else if (has_room)
                    state_next = fla_pkg::ST_IN_RD;
                else
                    state_next = fla_pkg::ST_LOST1;
            end
            fla_pkg::ST_F_NXT_MRG: state_next = fla_pkg::ST_S_INIT;
            fla_pkg::ST_IN_RD:     state_next = (k_reg == i_reg) ? fla_pkg::ST_IN_PUT
                                                                 : fla_pkg::ST_IN_WR;
            fla_pkg::ST_IN_WR:     state_next = fla_pkg::ST_IN_RD;
            fla_pkg::ST_IN_PUT:    state_next = fla_pkg::ST_S_INIT;
            fla_pkg::ST_LOST1:     state_next = fla_pkg::ST_LOST2;
            fla_pkg::ST_LOST2:     state_next = fla_pkg::ST_S_INIT;
            fla_pkg::ST_S_INIT:    state_next = fla_pkg::ST_S_RD;
            fla_pkg::ST_S_RD:      state_next = (k_reg == count_reg) ? fla_pkg::ST_FINISH
                                                                     : fla_pkg::ST_S_ADD;
            fla_pkg::ST_S_ADD:     state_next = fla_pkg::ST_S_RD;
            fla_pkg::ST_FINISH:    if (can_load) state_next = fla_pkg::ST_IDLE;
            default:               state_next = fla_pkg::ST_IDLE;
        endcase
    end

    // Datapath, table port and shared adder control
    always_comb
    begin
        count_next      = count_reg;
        peak_next       = peak_reg;
        lost_cnt_next   = lost_cnt_reg;
        lost_bytes_next = lost_bytes_reg;
        func_next       = func_reg;
        round_next      = round_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        cur_start_next  = cur_start_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        next_start_next = next_start_reg;
        next_len_next   = next_len_reg;
        next_ok_next    = next_ok_reg;
        tmp_next        = tmp_reg;
        sum_next        = sum_reg;
        got_next        = got_reg;
        stat_next       = stat_reg;
        o_status_next   = o_status_reg;
        o_addr_next     = o_addr_reg;
        o_total_next    = o_total_reg;
        o_count_next    = o_count_reg;
        o_peak_next     = o_peak_reg;
        o_lcnt_next     = o_lcnt_reg;
        o_lbytes_next   = o_lbytes_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        alu_req         = '{op: fla_pkg::ALU_ADD, a: '0, b: '0};

        case (state_reg)
            fla_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    addr_next  = addr;
                    size_next  = size;
                    round_next = page_round;
                end
            end
            fla_pkg::ST_PREP:
            begin
                alu_req      = '{op: fla_pkg::ALU_ADD, a: size_reg, b: fla_pkg::PAGE_MASK_LOW};
                if (round_reg)
                    size_next = alu_rsp.res & fla_pkg::PAGE_MASK_HIGH;
                i_next       = '0;
                got_next     = '0;
                next_ok_next = 1'b0;
                stat_next    = fla_pkg::STAT_OK;
            end
            fla_pkg::ST_A_RD:
            begin
                ram_raddr = i_reg[IDX_W-1:0];
                if (at_end)
                    stat_next = fla_pkg::STAT_NOFIT;
            end
            fla_pkg::ST_A_CHK:
            begin
                // carry out of length minus size means the range fits
                alu_req        = '{op: fla_pkg::ALU_SUB, a: rd_len, b: size_reg};
                tmp_next       = alu_rsp.res;
                cur_start_next = rd_start;
                if (alu_rsp.carry)
                    got_next = rd_start;
                else
                    i_next = i_reg + CNT_W'(1);
            end
            fla_pkg::ST_A_UPD:
            begin
                alu_req = '{op: fla_pkg::ALU_ADD, a: cur_start_reg, b: size_reg};
                if (tmp_reg == '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                    k_next     = i_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = i_reg[IDX_W-1:0];
                    ram_wdata = {alu_rsp.res, tmp_reg};
                end
            end
            fla_pkg::ST_RM_RD:
            begin
                ram_raddr = k_inc[IDX_W-1:0];
            end
            fla_pkg::ST_RM_WR:
            begin
                // pull the following entry down one place
                ram_we    = 1'b1;
                ram_waddr = k_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                k_next    = k_inc;
            end
            fla_pkg::ST_F_RD:
            begin
                ram_raddr = i_reg[IDX_W-1:0];
            end
            fla_pkg::ST_F_CHK:
            begin
                // no carry out of addr minus start means the entry starts above addr
                alu_req = '{op: fla_pkg::ALU_SUB, a: addr_reg, b: rd_start};
                if (alu_rsp.carry)
                begin
                    prev_start_next = rd_start;
                    prev_len_next   = rd_len;
                    i_next          = i_reg + CNT_W'(1);
                end
                else
                begin
                    next_start_next = rd_start;
                    next_len_next   = rd_len;
                    next_ok_next    = 1'b1;
                end
            end
            fla_pkg::ST_F_PREV:
            begin
                alu_req = '{op: fla_pkg::ALU_ADD, a: prev_start_reg, b: prev_len_reg};
            end
            fla_pkg::ST_F_MRG:
            begin
                alu_req  = '{op: fla_pkg::ALU_ADD, a: prev_len_reg, b: size_reg};
                tmp_next = alu_rsp.res;
            end
            fla_pkg::ST_F_MRG_CHK:
            begin
                alu_req = '{op: fla_pkg::ALU_ADD, a: addr_reg, b: size_reg};
                if (!sum_eq_next)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = i_dec[IDX_W-1:0];
                    ram_wdata = {prev_start_reg, tmp_reg};
                end
            end
            fla_pkg::ST_F_MRG2:
            begin
                // absorb the following range, then drop its entry
                alu_req    = '{op: fla_pkg::ALU_ADD, a: tmp_reg, b: next_len_reg};
                ram_we     = 1'b1;
                ram_waddr  = i_dec[IDX_W-1:0];
                ram_wdata  = {prev_start_reg, alu_rsp.res};
                count_next = count_reg - CNT_W'(1);
                k_next     = i_reg;
            end
            fla_pkg::ST_F_NEXT:
            begin
                alu_req = '{op: fla_pkg::ALU_ADD, a: addr_reg, b: size_reg};
                k_next  = count_reg;
            end
            fla_pkg::ST_F_NXT_MRG:
            begin
                alu_req   = '{op: fla_pkg::ALU_ADD, a: next_len_reg, b: size_reg};
                ram_we    = 1'b1;
                ram_waddr = i_reg[IDX_W-1:0];
                ram_wdata = {addr_reg, alu_rsp.res};
            end
            fla_pkg::ST_IN_RD:
            begin
                ram_raddr = k_dec[IDX_W-1:0];
            end
            fla_pkg::ST_IN_WR:
            begin
                // push the preceding entry up one place
                ram_we    = 1'b1;
                ram_waddr = k_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                k_next    = k_dec;
            end
            fla_pkg::ST_IN_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[IDX_W-1:0];
                ram_wdata  = {addr_reg, size_reg};
                count_next = count_inc;
                if (peak_reg < count_inc)
                    peak_next = count_inc;
            end
            fla_pkg::ST_LOST1:
            begin
                alu_req       = '{op: fla_pkg::ALU_ADD, a: lost_cnt_reg, b: DW'(1)};
                lost_cnt_next = sat_res;
                stat_next     = fla_pkg::STAT_LOST;
            end
            fla_pkg::ST_LOST2:
            begin
                alu_req         = '{op: fla_pkg::ALU_ADD, a: lost_bytes_reg, b: size_reg};
                lost_bytes_next = sat_res;
            end
            fla_pkg::ST_S_INIT:
            begin
                sum_next = '0;
                k_next   = '0;
            end
            fla_pkg::ST_S_RD:
            begin
                ram_raddr = k_reg[IDX_W-1:0];
            end
            fla_pkg::ST_S_ADD:
            begin
                alu_req  = '{op: fla_pkg::ALU_ADD, a: sum_reg, b: rd_len};
                sum_next = sat_res;
                k_next   = k_inc;
            end
            fla_pkg::ST_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = stat_reg;
                    o_addr_next    = got_reg;
                    o_total_next   = sum_reg;
                    o_count_next   = 9'(count_reg);
                    o_peak_next    = 9'(peak_reg);
                    o_lcnt_next    = lost_cnt_reg;
                    o_lbytes_next  = lost_bytes_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fla_pkg::ST_IDLE;
            count_reg      <= '0;
            peak_reg       <= '0;
            lost_cnt_reg   <= '0;
            lost_bytes_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            peak_reg       <= peak_next;
            lost_cnt_reg   <= lost_cnt_next;
            lost_bytes_reg <= lost_bytes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        round_reg      <= round_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        cur_start_reg  <= cur_start_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        next_start_reg <= next_start_next;
        next_len_reg   <= next_len_next;
        next_ok_reg    <= next_ok_next;
        tmp_reg        <= tmp_next;
        sum_reg        <= sum_next;
        got_reg        <= got_next;
        stat_reg       <= stat_next;
        o_status_reg   <= o_status_next;
        o_addr_reg     <= o_addr_next;
        o_total_reg    <= o_total_next;
        o_count_reg    <= o_count_next;
        o_peak_reg     <= o_peak_next;
        o_lcnt_reg     <= o_lcnt_next;
        o_lbytes_reg   <= o_lbytes_next;
    end

    assign in_stall     = (state_reg != fla_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign alloc_addr   = o_addr_reg;
    assign free_total   = o_total_reg;
    assign entry_count  = o_count_reg;
    assign peak_entries = o_peak_reg;
    assign lost_count   = o_lcnt_reg;
    assign lost_bytes   = o_lbytes_reg;

endmodule

>>> rtl/core/fla_checker.sv
// Port-level assertions for the free list allocator, bound to the top level.
module fla_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] alloc_addr,
    input logic [31:0] lost_count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // busy right after taking a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != fla_pkg::STAT_OK |-> alloc_addr == 32'd0)
        else $error("address reported on a failed request");

    a_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fla_pkg::STAT_LOST |-> lost_count != 32'd0)
        else $error("dropped free not counted");

endmodule

bind free_list_allocator fla_checker u_fla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_addr (alloc_addr),
    .lost_count (lost_count)
);

>>> dv/tb_free_list_allocator.sv
// Self-checking testbench for the first-fit free list allocator.
module tb_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 256;
    localparam int DRAIN_CYCLES = 6 * TABLE_DEPTH + 20;
    localparam int STUCK_LIMIT  = 40000;
    localparam int RANDOM_ITEMS = 510;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct {
        fla_pkg::fla_status_t status;
        logic [31:0] alloc_addr;
        logic [31:0] free_total;
        logic [8:0]  entry_count;
        logic [8:0]  peak_entries;
        logic [31:0] lost_count;
        logic [31:0] lost_bytes;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [31:0] addr;
    logic [31:0] size;
    logic        page_round;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] alloc_addr;
    logic [31:0] free_total;
    logic [8:0]  entry_count;
    logic [8:0]  peak_entries;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;

    // predictor state
    logic [31:0] free_start[TABLE_DEPTH];
    logic [31:0] free_len[TABLE_DEPTH];
    int          held;
    int          held_peak;
    logic [31:0] drop_cnt;
    logic [31:0] drop_bytes;

    alloc_result_t pending_results[$];
    int            mismatches;
    int            burst_left;
    int            stuck_cycles;
    int            stall_phase;
    int            stall_mode;

    free_list_allocator #(.ENTRIES(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .addr(addr), .size(size), .page_round(page_round),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .alloc_addr(alloc_addr), .free_total(free_total),
        .entry_count(entry_count), .peak_entries(peak_entries),
        .lost_count(lost_count), .lost_bytes(lost_bytes)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[32] ? fla_pkg::ALL_ONES : t[31:0];
    endfunction

    function automatic void close_gap(input int pos);
        held--;
        for (int k = pos; k < held; k++)
        begin
            free_start[k] = free_start[k + 1];
            free_len[k]   = free_len[k + 1];
        end
    endfunction

    // Work out the result of one request and update the free list copy.
    task automatic predict_request(input logic f, input logic [31:0] a,
                                   input logic [31:0] sz_in, input logic pr);
        logic [31:0]   sz;
        logic [31:0]   sum;
        int            i;
        bit            done;
        alloc_result_t r;
        sz = pr ? ((sz_in + fla_pkg::PAGE_MASK_LOW) & fla_pkg::PAGE_MASK_HIGH) : sz_in;
        r.alloc_addr = '0;
        r.status = fla_pkg::STAT_OK;
        if (f == FUNC_ALLOC)
        begin
            r.status = fla_pkg::STAT_NOFIT;
            for (i = 0; i < held; i++)
            begin
                if (free_len[i] >= sz)
                begin
                    r.status = fla_pkg::STAT_OK;
                    r.alloc_addr = free_start[i];
                    free_start[i] += sz;
                    free_len[i] -= sz;
                    if (free_len[i] == 0)
                        close_gap(i);
                    break;
                end
            end
        end
        else
        begin
            done = 0;
            for (i = 0; i < held; i++)
                if (free_start[i] > a)
                    break;
            if (i > 0 && free_start[i - 1] + free_len[i - 1] == a)
            begin
                free_len[i - 1] += sz;
                if (i < held && a + sz == free_start[i])
                begin
                    free_len[i - 1] += free_len[i];
                    close_gap(i);
                end
                done = 1;
            end
            else if (i < held && a + sz == free_start[i])
            begin
                free_start[i] = a;
                free_len[i] += sz;
                done = 1;
            end
            else if (held < TABLE_DEPTH)
            begin
                for (int k = held; k > i; k--)
                begin
                    free_start[k] = free_start[k - 1];
                    free_len[k]   = free_len[k - 1];
                end
                held++;
                if (held_peak < held)
                    held_peak = held;
                free_start[i] = a;
                free_len[i]   = sz;
                done = 1;
            end
            if (!done)
            begin
                drop_cnt   = sat_add32(drop_cnt, 32'd1);
                drop_bytes = sat_add32(drop_bytes, sz);
                r.status = fla_pkg::STAT_LOST;
            end
        end
        sum = '0;
        for (i = 0; i < held; i++)
            sum = sat_add32(sum, free_len[i]);
        r.free_total   = sum;
        r.entry_count  = held[8:0];
        r.peak_entries = held_peak[8:0];
        r.lost_count   = drop_cnt;
        r.lost_bytes   = drop_bytes;
        pending_results.push_back(r);
    endtask

    // Send one transaction; bursts with random gaps between them.
    task automatic send_request(input logic f, input logic [31:0] a,
                                input logic [31:0] sz, input logic pr);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        func       <= f;
        addr       <= a;
        size       <= sz;
        page_round <= pr;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_request(f, a, sz, pr);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(status), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (alloc_addr !== want.alloc_addr)
                    report_mismatch("alloc_addr", alloc_addr, want.alloc_addr);
                if (free_total !== want.free_total)
                    report_mismatch("free_total", free_total, want.free_total);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
                if (peak_entries !== want.peak_entries)
                    report_mismatch("peak_entries", 32'(peak_entries), 32'(want.peak_entries));
                if (lost_count !== want.lost_count)
                    report_mismatch("lost_count", lost_count, want.lost_count);
                if (lost_bytes !== want.lost_bytes)
                    report_mismatch("lost_bytes", lost_bytes, want.lost_bytes);
            end
        end
    end

    // Receiver stall pattern: switch between free-running, random, heavy and periodic stalls.
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(16, 200);
        end
        stall_phase--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= (stall_phase % 5 < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_list();
        send_request(FUNC_ALLOC, 32'h0, 32'h0, 1'b0);
        send_request(FUNC_ALLOC, fla_pkg::ALL_ONES, 32'h5, 1'b1);
        send_request(FUNC_ALLOC, 32'h0, fla_pkg::ALL_ONES, 1'b0);
    endtask

    task automatic test_merge_and_carve();
        send_request(FUNC_FREE, 32'h0000_1000, 32'h1000, 1'b0);
        send_request(FUNC_FREE, 32'h0000_3000, 32'h1000, 1'b0);
        send_request(FUNC_FREE, 32'h0000_2000, 32'h1000, 1'b0);  // joins both neighbors
        send_request(FUNC_FREE, 32'h0000_6000, 32'h0800, 1'b0);
        send_request(FUNC_FREE, 32'h0000_5800, 32'h0800, 1'b0);  // joins next only
        send_request(FUNC_FREE, 32'h0000_5800, 32'h0001, 1'b1);  // overlap, equal start
        send_request(FUNC_FREE, 32'h0000_9000, 32'h0, 1'b0);     // zero-length entry
        send_request(FUNC_FREE, 32'hffff_f000, 32'h2000, 1'b0);  // end wraps
        send_request(FUNC_FREE, fla_pkg::ALL_ONES, fla_pkg::ALL_ONES, 1'b1); // rounds to zero
        send_request(FUNC_ALLOC, 32'h0, 32'h0, 1'b0);
        send_request(FUNC_ALLOC, 32'h0, 32'h0800, 1'b0);
        send_request(FUNC_ALLOC, 32'h0, 32'h3800, 1'b0);         // no range is large enough
        send_request(FUNC_ALLOC, 32'h0, 32'h0001, 1'b1);
        send_request(FUNC_ALLOC, 32'h0, 32'hffff_f001, 1'b1);
        send_request(FUNC_ALLOC, 32'h0, fla_pkg::ALL_ONES, 1'b0);
        send_request(FUNC_ALLOC, 32'h0, 32'h2000, 1'b0);
        wait_drain();
    endtask

    task automatic test_table_full();
        for (int n = 0; n < TABLE_DEPTH + 2; n++)
            send_request(FUNC_FREE, 32'h8000_0000 + n * 32'h100, 32'h10, 1'b0);
        send_request(FUNC_FREE, 32'h0100_0000, fla_pkg::ALL_ONES, 1'b0);
        send_request(FUNC_FREE, 32'h0200_0000, fla_pkg::ALL_ONES, 1'b1);
        send_request(FUNC_FREE, 32'h0300_0000, fla_pkg::ALL_ONES, 1'b0);  // lost bytes stay saturated
        // Shrink the list back so random traffic stays fast.
        for (int n = 0; n < TABLE_DEPTH; n++)
            send_request(FUNC_ALLOC, $urandom, 32'h10, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int          pick;
        logic [31:0] a;
        logic [31:0] sz;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                a  = 32'h4000_0000 + $urandom_range(0, 255) * 32'h40;
                sz = $urandom_range(0, 8) * 32'h40;
                send_request(FUNC_FREE, a, sz, 1'b0);
            end
            else if (pick < 80)
                send_request(FUNC_ALLOC, $urandom, $urandom_range(0, 6) * 32'h40, 1'b0);
            else if (pick < 88)
                send_request(1'($urandom_range(0, 1)),
                             32'h4000_0000 + $urandom_range(0, 63) * 32'h1000,
                             $urandom_range(0, 8192), 1'b1);
            else
                send_request(1'($urandom_range(0, 1)), $urandom, $urandom,
                             1'($urandom_range(0, 1)));
            if (n == RANDOM_ITEMS / 2)
                wait_drain();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= FUNC_ALLOC;
        addr       <= '0;
        size       <= '0;
        page_round <= 1'b0;
        out_stall  <= 1'b0;
        held = 0;
        held_peak = 0;
        drop_cnt = '0;
        drop_bytes = '0;
        mismatches = 0;
        burst_left = 0;
        stuck_cycles = 0;
        stall_phase = 0;
        stall_mode = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_merge_and_carve();
        test_table_full();
        test_random_traffic();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
